/* hdl/lidar_point_camera_projection_assert.svh */
// Assertion macros for the projection block RTL, included by lpcp_back.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lpcp_pkg.sv */
// Shared types and constants for the lidar point projection block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lpcp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int Q_FRAC    = 14;
  localparam int SPAN_W    = 46;
  localparam int DEPTH_W   = 19;
  localparam int COLOR_W   = 8;
  localparam int SIZE_W    = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 19'd524287;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DLIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd7;

  localparam logic [63:0] RST_ROW0   = 64'd16384;
  localparam logic [63:0] RST_ROW1   = 64'd1073741824;
  localparam logic [63:0] RST_ROW2   = 64'd70368744177664;
  localparam logic [63:0] RST_FOCAL  = 64'd659706976819200;
  localparam logic [63:0] RST_PP     = 64'd263882790748160;
  localparam logic [63:0] RST_DLIM   = 64'd343597383680100;
  localparam logic [31:0] RST_IMG    = 32'd31457920;
  localparam logic [15:0] RST_STRIDE = 16'd1;

  typedef struct packed {
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] row2;
    logic [63:0] focal;
    logic [63:0] pp;
    logic [63:0] dlim;
    logic [31:0] img;
    logic [15:0] stride;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* hdl/lidar_point_camera_projection.sv */
// Top level of the lidar-to-camera point projection block.
// Holds the configuration registers; uses lpcp_front, lpcp_fifo, lpcp_back, lpcp_pkg.
//
//  channel  direction  signals                                  payload
//  in_      slave      in_tvalid in_tready in_tdata in_tuser    point x/y/z, first_of_cloud
//  out_     master     out_tvalid out_tready out_tdata           pixel u/v, depth, red, blue
//  cfg_     slave      cfg_valid cfg_ready cfg_index cfg_data    register write
//
// A kept point's time in the back end is set by the shared multiplier (9 transform and 8
// projection products, each one registered in a multiply state, then summed)
// and the shared restoring divider (PIXEL_BITS+1 steps per axis, 8 per colour).
// Points skipped by the stride never enter the queue; dropped points leave the back end early.
// A two-entry queue lets the front accept while the back end works or the output stalls.
// Synchronous active-low reset; configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_camera_projection #(
  parameter int COORD_BITS = 20,
  parameter int PIXEL_BITS = 13
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y, point_z
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // first_of_cloud
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // pixel_u, pixel_v, camera_depth, red_level, blue_level
  output logic [((2*PIXEL_BITS+35+7)/8)*8-1:0]   out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [63:0]                       cfg_data
);

  localparam int IN_W  = ((3*COORD_BITS+7)/8)*8;
  localparam int OUT_W = ((2*PIXEL_BITS+35+7)/8)*8;
  localparam int PAY_W = 2*PIXEL_BITS + 35;
  localparam int PT_W  = 3*COORD_BITS;

  lpcp_pkg::cfg_t    cfg_r;
  lpcp_pkg::q_stat_t q_stat;
  logic              push, pop;
  logic [PT_W-1:0]   push_data, q_data;
  logic [PIXEL_BITS-1:0] u, v;
  logic [lpcp_pkg::DEPTH_W-1:0] depth;
  logic [lpcp_pkg::COLOR_W-1:0] red, blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row0   <= lpcp_pkg::RST_ROW0;
      cfg_r.row1   <= lpcp_pkg::RST_ROW1;
      cfg_r.row2   <= lpcp_pkg::RST_ROW2;
      cfg_r.focal  <= lpcp_pkg::RST_FOCAL;
      cfg_r.pp     <= lpcp_pkg::RST_PP;
      cfg_r.dlim   <= lpcp_pkg::RST_DLIM;
      cfg_r.img    <= lpcp_pkg::RST_IMG;
      cfg_r.stride <= lpcp_pkg::RST_STRIDE;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpcp_pkg::REG_ROW0:   cfg_r.row0   <= cfg_data;
        lpcp_pkg::REG_ROW1:   cfg_r.row1   <= cfg_data;
        lpcp_pkg::REG_ROW2:   cfg_r.row2   <= cfg_data;
        lpcp_pkg::REG_FOCAL:  cfg_r.focal  <= cfg_data;
        lpcp_pkg::REG_PP:     cfg_r.pp     <= cfg_data;
        lpcp_pkg::REG_DLIM:   cfg_r.dlim   <= cfg_data;
        lpcp_pkg::REG_IMG:    cfg_r.img    <= cfg_data[31:0];
        lpcp_pkg::REG_STRIDE: cfg_r.stride <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lpcp_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stride    (cfg_r.stride),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lpcp_fifo #(
    .WIDTH (PT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .stat      (q_stat),
    .pop_data  (q_data)
  );

  lpcp_back #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_u     (u),
    .out_v     (v),
    .out_depth (depth),
    .out_red   (red),
    .out_blue  (blue)
  );

  assign out_tdata = {{(OUT_W-PAY_W){1'b0}}, blue, red, depth, v, u};

endmodule

`default_nettype wire

/* hdl/lpcp_fifo.sv */
// Two-entry point queue between the front and the back of the block.
// Depends on lpcp_pkg for the status bundle.
`timescale 1ns / 1ps
`default_nettype none

module lpcp_fifo #(
  parameter int WIDTH = 60
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output lpcp_pkg::q_stat_t     stat,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hdl/lpcp_front.sv */
// Front end: accepts points and applies the per-cloud sample stride.
// Depends on lpcp_pkg; feeds lpcp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module lpcp_front #(
  parameter int COORD_BITS = 20,
  parameter int IN_W       = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_W-1:0]         in_tdata,
  input  wire logic                    in_tuser,
  input  wire logic [15:0]             stride,
  input  wire lpcp_pkg::q_stat_t       q_stat,
  output logic                         push,
  output logic [3*COORD_BITS-1:0]      push_data
);

  logic [15:0] cd_r;
  logic [15:0] cd_nxt;
  logic [15:0] cd_cur;
  logic        accept;
  logic        keep;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign cd_cur    = in_tuser ? 16'd0 : cd_r;
  assign keep      = (cd_cur == 16'd0);
  assign push      = accept && keep;
  assign push_data = in_tdata[3*COORD_BITS-1:0];

  always_comb begin
    cd_nxt = cd_r;
    if (accept) begin
      if (!keep)                 cd_nxt = cd_cur - 16'd1;
      else if (stride == 16'd0)  cd_nxt = 16'd0;
      else                       cd_nxt = stride - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cd_r <= 16'd0;
    else        cd_r <= cd_nxt;
  end

endmodule

`default_nettype wire

/* hdl/lpcp_back.sv */
// Back end: transform, depth window, projection divides and depth colour.
// Depends on lpcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_camera_projection_assert.svh"

module lpcp_back #(
  parameter int COORD_BITS = 20,
  parameter int PIXEL_BITS = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lpcp_pkg::cfg_t            cfg,
  input  wire lpcp_pkg::q_stat_t         q_stat,
  input  wire logic [3*COORD_BITS-1:0]   q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [PIXEL_BITS-1:0]          out_u,
  output logic [PIXEL_BITS-1:0]          out_v,
  output logic [lpcp_pkg::DEPTH_W-1:0]   out_depth,
  output logic [lpcp_pkg::COLOR_W-1:0]   out_red,
  output logic [lpcp_pkg::COLOR_W-1:0]   out_blue
);

  localparam int C   = COORD_BITS;
  localparam int P   = PIXEL_BITS;
  localparam int AW  = C + 18;
  localparam int FW  = AW + 32;
  localparam int RW  = AW + 36;
  localparam int ZW  = AW + 14;
  localparam int SW  = lpcp_pkg::SPAN_W;
  localparam int LW  = lpcp_pkg::SIZE_W + 1;
  localparam int BPW = $clog2(P + 1);
  localparam logic [LW-1:0] PMAX = LW'(1) << P;

  typedef enum logic [3:0] {
    S_IDLE, S_XMUL, S_XACC, S_CHK, S_PMUL, S_PACC, S_PSET,
    S_DIV, S_PEND, S_CSET, S_EMIT
  } state_t;

  state_t                state_r;
  logic signed [C-1:0]   px_r, py_r, pz_r;
  logic [1:0]            row_r, term_r, mstep_r, phase_r;
  logic signed [AW-1:0]  acc_r, cx_r, cy_r, cz_r;
  logic signed [65:0]    prod_r;
  logic [FW-1:0]         fc_r, kz_r;
  logic                  neg_r;
  logic [RW-1:0]         rem_r, dsh_r;
  logic [P:0]            q_r;
  logic [BPW-1:0]        bit_r;
  logic [SW-1:0]         span_r, above_r, below_r;
  logic [P-1:0]          u_r, v_r;
  logic [7:0]            red_r;
  logic [7:0]            blue_r;
  logic [lpcp_pkg::DEPTH_W-1:0] depth_r;
  logic                  out_valid_r;
  logic [P-1:0]          out_u_r, out_v_r;
  logic [lpcp_pkg::DEPTH_W-1:0] out_depth_r;
  logic [7:0]            out_red_r, out_blue_r;

  logic [63:0]           row_sel;
  logic [15:0]           coef;
  logic signed [C-1:0]   coord;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [65:0]    prod;
  logic signed [AW-1:0]  xsum, xrow, c_sel;
  logic [AW-1:0]         mag, zu;
  logic [31:0]           f_sel, k_sel;
  logic [FW-1:0]         pterm;
  logic [FW:0]           n_val;
  logic                  n_neg;
  logic signed [ZW-1:0]  czw, zmin_w, zmax_w, zdif;
  logic                  in_win;
  logic [AW-1:0]         dq;
  logic [SW-1:0]         cdif;
  logic                  ge;
  logic [LW-1:0]         sz, lim;
  logic                  pfail;
  logic                  slot_free;
  logic [8:0]            col_sum;

  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    case (row_r)
      2'd0:    row_sel = cfg.row0;
      2'd1:    row_sel = cfg.row1;
      default: row_sel = cfg.row2;
    endcase
    case (term_r)
      2'd0:    begin coef = row_sel[15:0];  coord = px_r; end
      2'd1:    begin coef = row_sel[31:16]; coord = py_r; end
      default: begin coef = row_sel[47:32]; coord = pz_r; end
    endcase
  end

  assign c_sel = phase_r[0] ? cy_r : cx_r;
  assign f_sel = phase_r[0] ? cfg.focal[63:32] : cfg.focal[31:0];
  assign k_sel = phase_r[0] ? cfg.pp[63:32] : cfg.pp[31:0];
  assign mag   = c_sel[AW-1] ? AW'(-c_sel) : AW'(c_sel);
  assign zu    = AW'(cz_r);

  // One shared 33x33 signed multiplier for the transform and the projection.
  always_comb begin
    if (state_r == S_XMUL) begin
      mul_a = $signed({{17{coef[15]}}, coef});
      mul_b = $signed({{(33-C){coord[C-1]}}, coord});
    end else begin
      mul_a = $signed({1'b0, (mstep_r[1] ? k_sel : f_sel)});
      case (mstep_r)
        2'd0:    mul_b = $signed({1'b0, mag[31:0]});
        2'd1:    mul_b = $signed({{(65-AW){1'b0}}, mag[AW-1:32]});
        2'd2:    mul_b = $signed({1'b0, zu[31:0]});
        default: mul_b = $signed({{(65-AW){1'b0}}, zu[AW-1:32]});
      endcase
    end
  end
  assign prod = mul_a * mul_b;

  assign xsum  = acc_r + $signed(prod_r[AW-1:0]);
  assign xrow  = xsum + ($signed({{(AW-16){row_sel[63]}}, row_sel[63:48]}) <<< lpcp_pkg::Q_FRAC);
  assign pterm = mstep_r[0] ? (FW'(prod_r[63:0]) << 32) : FW'(prod_r[63:0]);

  always_comb begin
    n_neg = 1'b0;
    if (!c_sel[AW-1]) begin
      n_val = {1'b0, kz_r} + {1'b0, fc_r};
    end else if (fc_r > kz_r) begin
      n_val = {1'b0, fc_r - kz_r};
      n_neg = 1'b1;
    end else begin
      n_val = {1'b0, kz_r - fc_r};
    end
  end

  assign czw    = $signed({{(ZW-AW){cz_r[AW-1]}}, cz_r});
  assign zmin_w = $signed({{(ZW-46){1'b0}}, cfg.dlim[31:0], 14'b0});
  assign zmax_w = $signed({{(ZW-46){1'b0}}, cfg.dlim[63:32], 14'b0});
  assign in_win = (czw > zmin_w) && (czw < zmax_w);
  assign zdif   = czw + ZW'(1 << (lpcp_pkg::Q_FRAC - 1));
  assign dq     = zdif[ZW-1:lpcp_pkg::Q_FRAC];

  assign cdif = phase_r[0] ? above_r : below_r;
  assign ge   = (rem_r >= dsh_r);

  assign sz    = phase_r[0] ? LW'(cfg.img[31:16]) : LW'(cfg.img[15:0]);
  assign lim   = (sz > PMAX) ? PMAX : sz;
  assign pfail = (neg_r && (q_r != '0)) || (LW'(q_r) >= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            px_r    <= $signed(q_data[C-1:0]);
            py_r    <= $signed(q_data[2*C-1:C]);
            pz_r    <= $signed(q_data[3*C-1:2*C]);
            row_r   <= 2'd0;
            term_r  <= 2'd0;
            acc_r   <= '0;
            state_r <= S_XMUL;
          end
        end
        S_XMUL: begin
          prod_r  <= prod;
          state_r <= S_XACC;
        end
        S_XACC: begin
          if (term_r == 2'd2) begin
            case (row_r)
              2'd0:    cx_r <= xrow;
              2'd1:    cy_r <= xrow;
              default: cz_r <= xrow;
            endcase
            acc_r  <= '0;
            term_r <= 2'd0;
            row_r  <= row_r + 2'd1;
            state_r <= (row_r == 2'd2) ? S_CHK : S_XMUL;
          end else begin
            acc_r   <= xsum;
            term_r  <= term_r + 2'd1;
            state_r <= S_XMUL;
          end
        end
        S_CHK: begin
          if (!in_win) begin
            state_r <= S_IDLE;
          end else begin
            span_r  <= SW'(zmax_w - zmin_w);
            above_r <= SW'(czw - zmin_w);
            below_r <= SW'(zmax_w - czw);
            depth_r <= (dq > AW'(lpcp_pkg::DEPTH_MAX)) ? lpcp_pkg::DEPTH_MAX
                                                        : dq[lpcp_pkg::DEPTH_W-1:0];
            phase_r <= 2'd0;
            mstep_r <= 2'd0;
            fc_r    <= '0;
            kz_r    <= '0;
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          prod_r  <= prod;
          state_r <= S_PACC;
        end
        S_PACC: begin
          if (mstep_r[1]) kz_r <= kz_r + pterm;
          else            fc_r <= fc_r + pterm;
          mstep_r <= mstep_r + 2'd1;
          state_r <= (mstep_r == 2'd3) ? S_PSET : S_PMUL;
        end
        S_PSET: begin
          // Numerator 2n + d over 2d, with d = z * 256, rounds half away from zero.
          neg_r   <= n_neg;
          rem_r   <= (RW'(n_val) << 1) + (RW'(zu) << 8);
          dsh_r   <= RW'(zu) << (9 + P);
          q_r     <= '0;
          bit_r   <= BPW'(P);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!phase_r[1] && (bit_r == BPW'(P)) && ge) begin
            // Quotient reaches 2^PIXEL_BITS: drop.
            state_r <= S_IDLE;
          end else begin
            if (ge) rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[P-1:0], ge};
            dsh_r <= dsh_r >> 1;
            bit_r <= bit_r - BPW'(1);
            if (bit_r == '0) state_r <= S_PEND;
          end
        end
        S_PEND: begin
          case (phase_r)
            2'd0: begin
              if (pfail) begin
                state_r <= S_IDLE;
              end else begin
                u_r     <= q_r[P-1:0];
                phase_r <= 2'd1;
                mstep_r <= 2'd0;
                fc_r    <= '0;
                kz_r    <= '0;
                state_r <= S_PMUL;
              end
            end
            2'd1: begin
              if (pfail) begin
                state_r <= S_IDLE;
              end else begin
                v_r     <= q_r[P-1:0];
                phase_r <= 2'd2;
                state_r <= S_CSET;
              end
            end
            2'd2: begin
              red_r   <= q_r[7:0];
              phase_r <= 2'd3;
              state_r <= S_CSET;
            end
            default: begin
              blue_r  <= q_r[7:0];
              state_r <= S_EMIT;
            end
          endcase
        end
        S_CSET: begin
          // (510 * diff + span) / (2 * span); red uses the distance to max.
          rem_r   <= (RW'(cdif) << 9) - (RW'(cdif) << 1) + RW'(span_r);
          dsh_r   <= RW'(span_r) << 8;
          q_r     <= '0;
          bit_r   <= BPW'(7);
          state_r <= S_DIV;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_u_r     <= u_r;
            out_v_r     <= v_r;
            out_depth_r <= depth_r;
            out_red_r   <= red_r;
            out_blue_r  <= blue_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_u     = out_u_r;
  assign out_v     = out_v_r;
  assign out_depth = out_depth_r;
  assign out_red   = out_red_r;
  assign out_blue  = out_blue_r;
  assign col_sum   = {1'b0, out_red_r} + {1'b0, out_blue_r};

  `LPCP_ASSERT_IMP(a_color_sum, $rose(out_valid_r), (col_sum == 9'd255 || col_sum == 9'd256), "red plus blue off")
  `LPCP_ASSERT_NXT(a_emit, (state_r == S_EMIT && slot_free), out_valid_r, "result not posted")
  `LPCP_ASSERT_NXT(a_div_end, (state_r == S_DIV && bit_r == '0), (state_r == S_PEND), "divide overran")

endmodule

`default_nettype wire
